>>> sv/stramp_pkg.sv
`default_nettype none
package stramp_pkg;

    // command codes
    localparam logic [2:0] CMD_ABS  = 3'd0;
    localparam logic [2:0] CMD_REL  = 3'd1;
    localparam logic [2:0] CMD_STOP = 3'd2;
    localparam logic [2:0] CMD_SOFT = 3'd3;
    localparam logic [2:0] CMD_TICK = 3'd4;
    localparam logic [2:0] CMD_HOME = 3'd5;

    // ramp phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ACCEL = 2'd1;
    localparam logic [1:0] PH_CONST = 2'd2;
    localparam logic [1:0] PH_DECEL = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_MAX_SPEED   = 2'd0;
    localparam logic [1:0] REG_ACCEL_RATE  = 2'd1;
    localparam logic [1:0] REG_MIN_SPEED   = 2'd2;
    localparam logic [1:0] REG_TIMER_CLOCK = 2'd3;

    localparam int CFG_W = 27;
    localparam logic [15:0] RST_MAX_SPEED   = 16'd2000;
    localparam logic [15:0] RST_ACCEL_RATE  = 16'd4000;
    localparam logic [15:0] RST_MIN_SPEED   = 16'd100;
    localparam logic [26:0] RST_TIMER_CLOCK = 27'd1000000;

    localparam logic [15:0] IV_MIN    = 16'd20;
    localparam logic [15:0] IV_MAX    = 16'd65535;
    localparam logic [15:0] IV_LIMIT  = 16'd65000;
    localparam logic [15:0] IV_DEC_LO = 16'd10;

    // shared divider size
    localparam int DIV_NW = 32;
    localparam int DIV_DW = 34;
    localparam logic [5:0] DIV_STEPS = 6'd32;

    // datapath operations
    localparam logic [4:0] OP_NONE     = 5'd0;
    localparam logic [4:0] OP_CAP      = 5'd1;
    localparam logic [4:0] OP_MV_DIFF  = 5'd2;
    localparam logic [4:0] OP_MUL_HI   = 5'd3;
    localparam logic [4:0] OP_MUL_LO   = 5'd4;
    localparam logic [4:0] OP_DIV      = 5'd5;
    localparam logic [4:0] OP_ACC_ZERO = 5'd6;
    localparam logic [4:0] OP_ACC_Q    = 5'd7;
    localparam logic [4:0] OP_MV_DP    = 5'd8;
    localparam logic [4:0] OP_MV_IV    = 5'd9;
    localparam logic [4:0] OP_STOP     = 5'd10;
    localparam logic [4:0] OP_SOFT     = 5'd11;
    localparam logic [4:0] OP_HOME     = 5'd12;
    localparam logic [4:0] OP_STEP     = 5'd13;
    localparam logic [4:0] OP_PD_C     = 5'd14;
    localparam logic [4:0] OP_PD_SUBQ  = 5'd15;
    localparam logic [4:0] OP_PD_Q     = 5'd16;
    localparam logic [4:0] OP_PD_INC   = 5'd17;
    localparam logic [4:0] OP_SPD_Q    = 5'd18;
    localparam logic [4:0] OP_SPD_ZERO = 5'd19;
    localparam logic [4:0] OP_TO_CONST = 5'd20;
    localparam logic [4:0] OP_TO_DECEL = 5'd21;
    localparam logic [4:0] OP_REM      = 5'd22;
    localparam logic [4:0] OP_SET_IV   = 5'd23;
    localparam logic [4:0] OP_OUT      = 5'd24;

    // divider operand selects
    localparam logic [2:0] DS_RAMP   = 3'd0;
    localparam logic [2:0] DS_TC_MIN = 3'd1;
    localparam logic [2:0] DS_TC_MAX = 3'd2;
    localparam logic [2:0] DS_TC_PD  = 3'd3;
    localparam logic [2:0] DS_DEC    = 3'd4;
    localparam logic [2:0] DS_INC    = 3'd5;

    typedef struct packed {
        logic [4:0] op;
        logic [2:0] dsel;
    } t_cmd;

    typedef struct packed {
        logic [2:0] cmd;
        logic       d_zero;
        logic       running;
        logic [1:0] phase;
        logic       hi_le_lo;
        logic       dec_ok;
        logic       pd_zero;
        logic       to_const;
        logic       rem_le1;
        logic       c_lt_lim;
        logic       rem_le_acc1;
        logic       spd_lt_min;
        logic       div_busy;
    } t_status;

    // clamp a timer count to the reload range
    function automatic logic [15:0] clamp_iv(input logic [31:0] v);
        logic [15:0] r;
        if (v < {16'd0, IV_MIN}) r = IV_MIN;
        else if (v > {16'd0, IV_MAX}) r = IV_MAX;
        else r = v[15:0];
        return r;
    endfunction

    function automatic logic [15:0] nz16(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage
`default_nettype wire

>>> sv/stramp_div.sv
`default_nettype none
module stramp_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [stramp_pkg::DIV_NW-1:0] i_num,
    input  wire logic [stramp_pkg::DIV_DW-1:0] i_den,
    output logic                               o_busy,
    output logic [stramp_pkg::DIV_NW-1:0]      o_quot
);

    logic                          r_busy;
    logic [5:0]                    r_cnt;
    logic [stramp_pkg::DIV_NW-1:0] r_num;
    logic [stramp_pkg::DIV_DW-1:0] r_den;
    logic [stramp_pkg::DIV_DW-1:0] r_rem;
    logic [stramp_pkg::DIV_DW:0]   trial;
    logic                          qbit;

    // one restoring step per cycle
    always_comb begin
        trial = {r_rem, r_num[stramp_pkg::DIV_NW-1]};
        qbit  = (trial >= {1'b0, r_den});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 6'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= stramp_pkg::DIV_STEPS;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) r_busy <= 1'b0;
        end
    end

    // shift registers, quotient collects in r_num
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[stramp_pkg::DIV_NW-2:0], qbit};
            if (qbit) r_rem <= trial[stramp_pkg::DIV_DW-1:0] - r_den;
            else      r_rem <= trial[stramp_pkg::DIV_DW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_num;

endmodule
`default_nettype wire

>>> sv/stramp_dp.sv
`default_nettype none
module stramp_dp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [1:0]           i_cfg_idx,
    input  wire logic [26:0]          i_cfg_wdata,
    input  wire logic [2:0]           i_cmd,
    input  wire logic signed [31:0]   i_move_value,
    input  wire stramp_pkg::t_cmd     i_ctl,
    output stramp_pkg::t_status       o_st,
    output logic                      o_step_pulse,
    output logic                      o_direction,
    output logic [15:0]               o_next_interval,
    output logic signed [31:0]        o_position_now,
    output logic                      o_is_running,
    output logic                      o_move_done
);

    logic [15:0] r_max, r_accr, r_min;
    logic [26:0] r_tc;
    logic [31:0] r_pos, r_tgt, r_steps, r_dp;
    logic [1:0]  r_phase;
    logic        r_run, r_dir;
    logic [15:0] r_iv;
    logic [2:0]  r_cmd;
    logic [31:0] r_val, r_mag, r_hi, r_lo, r_acc, r_rem;
    logic [26:0] r_pd, r_spd;
    logic        r_pulse, r_done;

    logic [31:0] tgt, pos_n, q, dist_abs;
    logic [32:0] d, d2, sum_iv;
    logic        div_start, div_busy;
    logic [stramp_pkg::DIV_NW-1:0] div_num;
    logic [stramp_pkg::DIV_DW-1:0] div_den;

    // move target and signed differences
    always_comb begin
        tgt      = (r_cmd == stramp_pkg::CMD_ABS) ? r_val : r_pos + r_val;
        d        = {tgt[31], tgt} - {r_pos[31], r_pos};
        d2       = {r_tgt[31], r_tgt} - {r_pos[31], r_pos};
        dist_abs = d2[32] ? 32'(-d2) : d2[31:0];
        pos_n    = r_dir ? r_pos - 32'd1 : r_pos + 32'd1;
        sum_iv   = {17'd0, r_iv} + {16'd0, q[16:0]};
    end

    // divider operand select
    always_comb begin
        div_start = (i_ctl.op == stramp_pkg::OP_DIV);
        case (i_ctl.dsel)
            stramp_pkg::DS_RAMP: begin
                div_num = r_hi - r_lo;
                div_den = {17'd0, stramp_pkg::nz16(r_accr), 1'b0};
            end
            stramp_pkg::DS_TC_MIN: begin
                div_num = {5'd0, r_tc};
                div_den = {18'd0, stramp_pkg::nz16(r_min)};
            end
            stramp_pkg::DS_TC_MAX: begin
                div_num = {5'd0, r_tc};
                div_den = {18'd0, stramp_pkg::nz16(r_max)};
            end
            stramp_pkg::DS_TC_PD: begin
                div_num = {5'd0, r_tc};
                div_den = {7'd0, r_pd};
            end
            stramp_pkg::DS_DEC: begin
                div_num = {15'd0, r_iv, 1'b0};
                div_den = {r_steps, 2'b01};
            end
            stramp_pkg::DS_INC: begin
                div_num = {15'd0, r_iv, 1'b0};
                div_den = {r_rem, 2'b01};
            end
            default: begin
                div_num = {5'd0, r_tc};
                div_den = {18'd0, stramp_pkg::nz16(r_min)};
            end
        endcase
    end

    stramp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (q)
    );

    // status to the controller
    always_comb begin
        o_st.cmd         = r_cmd;
        o_st.d_zero      = (d == 33'd0);
        o_st.running     = r_run;
        o_st.phase       = r_phase;
        o_st.hi_le_lo    = (r_hi <= r_lo);
        o_st.dec_ok      = (r_steps != 32'd0) && (r_iv > stramp_pkg::IV_DEC_LO);
        o_st.pd_zero     = (r_pd == 27'd0);
        o_st.to_const    = ({5'd0, r_spd} >= {16'd0, r_max}) || (r_steps >= r_dp);
        o_st.rem_le1     = (r_rem <= 32'd1);
        o_st.c_lt_lim    = (r_iv < stramp_pkg::IV_LIMIT);
        o_st.rem_le_acc1 = ({1'b0, r_rem} <= ({1'b0, r_acc} + 33'd1));
        o_st.spd_lt_min  = ({5'd0, r_spd} < {16'd0, r_min}) ;
        o_st.div_busy    = div_busy;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max  <= stramp_pkg::RST_MAX_SPEED;
            r_accr <= stramp_pkg::RST_ACCEL_RATE;
            r_min  <= stramp_pkg::RST_MIN_SPEED;
            r_tc   <= stramp_pkg::RST_TIMER_CLOCK;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                stramp_pkg::REG_MAX_SPEED:   r_max  <= i_cfg_wdata[15:0];
                stramp_pkg::REG_ACCEL_RATE:  r_accr <= i_cfg_wdata[15:0];
                stramp_pkg::REG_MIN_SPEED:   r_min  <= i_cfg_wdata[15:0];
                stramp_pkg::REG_TIMER_CLOCK: r_tc   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // motion state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_tgt   <= '0;
            r_phase <= stramp_pkg::PH_IDLE;
            r_run   <= 1'b0;
            r_dir   <= 1'b0;
            r_steps <= '0;
            r_iv    <= stramp_pkg::IV_MAX;
            r_dp    <= '0;
        end else begin
            case (i_ctl.op)
                stramp_pkg::OP_MV_DIFF: begin
                    r_dir <= d[32];
                    r_tgt <= tgt;
                end
                stramp_pkg::OP_MV_DP: begin
                    if ({1'b0, r_mag} <= {r_acc, 1'b0}) r_dp <= {1'b0, r_mag[31:1]};
                    else r_dp <= r_mag - r_acc;
                end
                stramp_pkg::OP_MV_IV: begin
                    r_iv    <= stramp_pkg::clamp_iv(q);
                    r_phase <= stramp_pkg::PH_ACCEL;
                    r_run   <= 1'b1;
                    r_steps <= '0;
                end
                stramp_pkg::OP_STOP: begin
                    r_phase <= stramp_pkg::PH_IDLE;
                    r_run   <= 1'b0;
                end
                stramp_pkg::OP_SOFT: begin
                    if (r_run) begin
                        r_phase <= stramp_pkg::PH_DECEL;
                        r_dp    <= '0;
                    end
                end
                stramp_pkg::OP_HOME: begin
                    r_pos <= '0;
                    r_tgt <= '0;
                end
                stramp_pkg::OP_STEP: begin
                    r_pos   <= pos_n;
                    r_steps <= r_steps + 32'd1;
                    if (pos_n == r_tgt) begin
                        r_phase <= stramp_pkg::PH_IDLE;
                        r_run   <= 1'b0;
                    end
                end
                stramp_pkg::OP_TO_CONST: r_phase <= stramp_pkg::PH_CONST;
                stramp_pkg::OP_TO_DECEL: r_phase <= stramp_pkg::PH_DECEL;
                stramp_pkg::OP_SET_IV:   r_iv    <= stramp_pkg::clamp_iv({5'd0, r_pd});
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            stramp_pkg::OP_CAP: begin
                r_cmd   <= i_cmd;
                r_val   <= i_move_value;
                r_pulse <= 1'b0;
                r_done  <= 1'b0;
            end
            stramp_pkg::OP_MV_DIFF:  r_mag <= d[32] ? 32'(-d) : d[31:0];
            stramp_pkg::OP_MUL_HI:   r_hi  <= r_max * r_max;
            stramp_pkg::OP_MUL_LO:   r_lo  <= r_min * r_min;
            stramp_pkg::OP_ACC_ZERO: r_acc <= '0;
            stramp_pkg::OP_ACC_Q:    r_acc <= q;
            stramp_pkg::OP_STEP: begin
                r_pulse <= 1'b1;
                r_done  <= (pos_n == r_tgt);
            end
            stramp_pkg::OP_PD_C:     r_pd  <= {11'd0, r_iv};
            stramp_pkg::OP_PD_SUBQ: begin
                if (q < {16'd0, r_iv}) r_pd <= {11'd0, r_iv - q[15:0]};
            end
            stramp_pkg::OP_PD_Q:     r_pd  <= q[26:0];
            stramp_pkg::OP_PD_INC: begin
                if (sum_iv > {17'd0, stramp_pkg::IV_MAX}) r_pd <= {11'd0, stramp_pkg::IV_MAX};
                else r_pd <= sum_iv[26:0];
            end
            stramp_pkg::OP_SPD_Q:    r_spd <= q[26:0];
            stramp_pkg::OP_SPD_ZERO: r_spd <= '0;
            stramp_pkg::OP_REM:      r_rem <= dist_abs;
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.op == stramp_pkg::OP_OUT) begin
            o_step_pulse    <= r_pulse;
            o_direction     <= r_dir;
            o_next_interval <= r_iv;
            o_position_now  <= r_pos;
            o_is_running    <= r_run;
            o_move_done     <= r_done;
        end
    end

endmodule
`default_nettype wire

>>> sv/stramp_ctrl.sv
`default_nettype none
module stramp_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    output logic                     o_valid,
    input  wire logic                i_ready,
    input  wire stramp_pkg::t_status i_st,
    output stramp_pkg::t_cmd         o_ctl
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DISP    = 5'd1;
    localparam logic [4:0] S_RS_HI   = 5'd2;
    localparam logic [4:0] S_RS_LO   = 5'd3;
    localparam logic [4:0] S_RS_CHK  = 5'd4;
    localparam logic [4:0] S_RS_ACC  = 5'd5;
    localparam logic [4:0] S_MV_DP   = 5'd6;
    localparam logic [4:0] S_MV_IV0  = 5'd7;
    localparam logic [4:0] S_MV_IV1  = 5'd8;
    localparam logic [4:0] S_DWAIT   = 5'd9;
    localparam logic [4:0] S_TK_BR   = 5'd10;
    localparam logic [4:0] S_TK_PH   = 5'd11;
    localparam logic [4:0] S_AC_SUB  = 5'd12;
    localparam logic [4:0] S_SPD0    = 5'd13;
    localparam logic [4:0] S_SPD_Q   = 5'd14;
    localparam logic [4:0] S_SPD_CHK = 5'd15;
    localparam logic [4:0] S_CN_DIV  = 5'd16;
    localparam logic [4:0] S_PD_Q    = 5'd17;
    localparam logic [4:0] S_CN_PD   = 5'd18;
    localparam logic [4:0] S_CN_REM  = 5'd19;
    localparam logic [4:0] S_CN_CHK  = 5'd20;
    localparam logic [4:0] S_DC_BR   = 5'd21;
    localparam logic [4:0] S_DC_INC  = 5'd22;
    localparam logic [4:0] S_DC_PDQ  = 5'd23;
    localparam logic [4:0] S_SET_IV  = 5'd24;
    localparam logic [4:0] S_FIN     = 5'd25;

    logic [4:0] r_state, n_state;
    logic [4:0] r_ret, n_ret;
    logic       r_ctx, n_ctx;
    logic       r_ov, n_ov;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_ctx      = r_ctx;
        n_ov       = r_ov & ~i_ready;
        o_ctl.op   = stramp_pkg::OP_NONE;
        o_ctl.dsel = stramp_pkg::DS_TC_MIN;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.op = stramp_pkg::OP_CAP;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_st.cmd) inside
                    stramp_pkg::CMD_ABS, stramp_pkg::CMD_REL: begin
                        if (i_st.d_zero) begin
                            n_state = S_FIN;
                        end else begin
                            o_ctl.op = stramp_pkg::OP_MV_DIFF;
                            n_ctx    = 1'b0;
                            n_state  = S_RS_HI;
                        end
                    end
                    stramp_pkg::CMD_STOP: begin
                        o_ctl.op = stramp_pkg::OP_STOP;
                        n_state  = S_FIN;
                    end
                    stramp_pkg::CMD_SOFT: begin
                        o_ctl.op = stramp_pkg::OP_SOFT;
                        n_state  = S_FIN;
                    end
                    stramp_pkg::CMD_HOME: begin
                        o_ctl.op = stramp_pkg::OP_HOME;
                        n_state  = S_FIN;
                    end
                    stramp_pkg::CMD_TICK: begin
                        if (i_st.running) o_ctl.op = stramp_pkg::OP_STEP;
                        n_state = i_st.running ? S_TK_BR : S_FIN;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            // ramp distance at cruise speed
            S_RS_HI: begin
                o_ctl.op = stramp_pkg::OP_MUL_HI;
                n_state  = S_RS_LO;
            end
            S_RS_LO: begin
                o_ctl.op = stramp_pkg::OP_MUL_LO;
                n_state  = S_RS_CHK;
            end
            S_RS_CHK: begin
                if (i_st.hi_le_lo) begin
                    o_ctl.op = stramp_pkg::OP_ACC_ZERO;
                    n_state  = r_ctx ? S_CN_CHK : S_MV_DP;
                end else begin
                    o_ctl.op   = stramp_pkg::OP_DIV;
                    o_ctl.dsel = stramp_pkg::DS_RAMP;
                    n_ret      = S_RS_ACC;
                    n_state    = S_DWAIT;
                end
            end
            S_RS_ACC: begin
                o_ctl.op = stramp_pkg::OP_ACC_Q;
                n_state  = r_ctx ? S_CN_CHK : S_MV_DP;
            end
            // move setup
            S_MV_DP: begin
                o_ctl.op = stramp_pkg::OP_MV_DP;
                n_state  = S_MV_IV0;
            end
            S_MV_IV0: begin
                o_ctl.op   = stramp_pkg::OP_DIV;
                o_ctl.dsel = stramp_pkg::DS_TC_MIN;
                n_ret      = S_MV_IV1;
                n_state    = S_DWAIT;
            end
            S_MV_IV1: begin
                o_ctl.op = stramp_pkg::OP_MV_IV;
                n_state  = S_FIN;
            end
            S_DWAIT: begin
                if (!i_st.div_busy) n_state = r_ret;
            end
            // tick
            S_TK_BR: begin
                if (i_st.running) begin
                    o_ctl.op = stramp_pkg::OP_PD_C;
                    n_state  = S_TK_PH;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_TK_PH: begin
                unique case (i_st.phase)
                    stramp_pkg::PH_ACCEL: begin
                        if (i_st.dec_ok) begin
                            o_ctl.op   = stramp_pkg::OP_DIV;
                            o_ctl.dsel = stramp_pkg::DS_DEC;
                            n_ret      = S_AC_SUB;
                            n_state    = S_DWAIT;
                        end else begin
                            n_state = S_SPD0;
                        end
                    end
                    stramp_pkg::PH_CONST: begin
                        o_ctl.op   = stramp_pkg::OP_DIV;
                        o_ctl.dsel = stramp_pkg::DS_TC_MAX;
                        n_ret      = S_CN_PD;
                        n_state    = S_DWAIT;
                    end
                    stramp_pkg::PH_DECEL: begin
                        o_ctl.op = stramp_pkg::OP_REM;
                        n_state  = S_DC_BR;
                    end
                    default: n_state = S_SET_IV;
                endcase
            end
            S_AC_SUB: begin
                o_ctl.op = stramp_pkg::OP_PD_SUBQ;
                n_state  = S_SPD0;
            end
            // speed from the new interval
            S_SPD0: begin
                if (i_st.pd_zero) begin
                    o_ctl.op = stramp_pkg::OP_SPD_ZERO;
                    n_state  = S_SPD_CHK;
                end else begin
                    o_ctl.op   = stramp_pkg::OP_DIV;
                    o_ctl.dsel = stramp_pkg::DS_TC_PD;
                    n_ret      = S_SPD_Q;
                    n_state    = S_DWAIT;
                end
            end
            S_SPD_Q: begin
                o_ctl.op = stramp_pkg::OP_SPD_Q;
                n_state  = S_SPD_CHK;
            end
            S_SPD_CHK: begin
                if (i_st.phase == stramp_pkg::PH_ACCEL) begin
                    if (i_st.to_const) begin
                        o_ctl.op = stramp_pkg::OP_TO_CONST;
                        n_state  = S_CN_DIV;
                    end else begin
                        n_state = S_SET_IV;
                    end
                end else if (i_st.spd_lt_min) begin
                    o_ctl.op   = stramp_pkg::OP_DIV;
                    o_ctl.dsel = stramp_pkg::DS_TC_MIN;
                    n_ret      = S_PD_Q;
                    n_state    = S_DWAIT;
                end else begin
                    n_state = S_SET_IV;
                end
            end
            S_CN_DIV: begin
                o_ctl.op   = stramp_pkg::OP_DIV;
                o_ctl.dsel = stramp_pkg::DS_TC_MAX;
                n_ret      = S_PD_Q;
                n_state    = S_DWAIT;
            end
            S_PD_Q: begin
                o_ctl.op = stramp_pkg::OP_PD_Q;
                n_state  = S_SET_IV;
            end
            // cruise
            S_CN_PD: begin
                o_ctl.op = stramp_pkg::OP_PD_Q;
                n_state  = S_CN_REM;
            end
            S_CN_REM: begin
                o_ctl.op = stramp_pkg::OP_REM;
                n_ctx    = 1'b1;
                n_state  = S_RS_HI;
            end
            S_CN_CHK: begin
                if (i_st.rem_le_acc1) o_ctl.op = stramp_pkg::OP_TO_DECEL;
                n_state = S_SET_IV;
            end
            // deceleration
            S_DC_BR: begin
                if (i_st.rem_le1) begin
                    o_ctl.op   = stramp_pkg::OP_DIV;
                    o_ctl.dsel = stramp_pkg::DS_TC_MIN;
                    n_ret      = S_DC_PDQ;
                    n_state    = S_DWAIT;
                end else if (i_st.c_lt_lim) begin
                    o_ctl.op   = stramp_pkg::OP_DIV;
                    o_ctl.dsel = stramp_pkg::DS_INC;
                    n_ret      = S_DC_INC;
                    n_state    = S_DWAIT;
                end else begin
                    n_state = S_SPD0;
                end
            end
            S_DC_INC: begin
                o_ctl.op = stramp_pkg::OP_PD_INC;
                n_state  = S_SPD0;
            end
            S_DC_PDQ: begin
                o_ctl.op = stramp_pkg::OP_PD_Q;
                n_state  = S_SPD0;
            end
            S_SET_IV: begin
                o_ctl.op = stramp_pkg::OP_SET_IV;
                n_state  = S_FIN;
            end
            // hand the result to the output register
            S_FIN: begin
                if (!r_ov || i_ready) begin
                    o_ctl.op = stramp_pkg::OP_OUT;
                    n_ov     = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_ctx   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_ctx   <= n_ctx;
            r_ov    <= n_ov;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ov;

endmodule
`default_nettype wire

>>> sv/stepper_trapezoid_ramp_core.sv
`default_nettype none
// Trapezoidal stepper ramp generator, linear speed ramp with interval recurrences.
// Input channel (i_valid/o_ready) carries one request: i_cmd and i_move_value.
// Commands: absolute move, relative move, hard stop, soft stop, timer tick,
// set home. Every request gives exactly one result on the output channel
// (o_valid/i_ready): step pulse, direction, next timer reload, position,
// running flag and move-done flag.
// Configuration is a plain write port (i_cfg_wr_en, i_cfg_idx, i_cfg_wdata)
// for max speed, acceleration, min speed and timer clock; write it when idle.
// One request is worked on at a time. A move or a running tick that does not
// reach the target uses the shared 32-step restoring divider up to three times;
// stop, soft stop, set home, idle ticks, moves to the current position and a
// tick that reaches the target do not use the divider at all.
// A finished result sits in the output register; the next request is taken
// while it waits, but the block holds its next result until the receiver
// takes the previous one. Synchronous reset restores the register defaults,
// position zero, idle phase and a reload of 65535; no clearing pass.
module stepper_trapezoid_ramp_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [26:0]        i_cfg_wdata,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [2:0]         i_cmd,
    input  wire logic signed [31:0] i_move_value,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_step_pulse,
    output logic                    o_direction,
    output logic [15:0]             o_next_interval,
    output logic signed [31:0]      o_position_now,
    output logic                    o_is_running,
    output logic                    o_move_done
);

    stramp_pkg::t_cmd    ctl;
    stramp_pkg::t_status st;

    // sequencer
    stramp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_st    (st),
        .o_ctl   (ctl)
    );

    // arithmetic and motion state
    stramp_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd           (i_cmd),
        .i_move_value    (i_move_value),
        .i_ctl           (ctl),
        .o_st            (st),
        .o_step_pulse    (o_step_pulse),
        .o_direction     (o_direction),
        .o_next_interval (o_next_interval),
        .o_position_now  (o_position_now),
        .o_is_running    (o_is_running),
        .o_move_done     (o_move_done)
    );

endmodule
`default_nettype wire

>>> sv/stramp_checker.sv
`default_nettype none
module stramp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic        o_step_pulse,
    input wire logic [15:0] o_next_interval,
    input wire logic        o_is_running,
    input wire logic        o_move_done
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // reaching the target ends the move
    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_move_done |-> !o_is_running)
        else $error("move done but still running");

    // only a stepping tick can finish a move
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_move_done |-> o_step_pulse)
        else $error("move done without a step");

    // reload stays in range
    a_iv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_next_interval >= 16'd20)
        else $error("reload below minimum");

endmodule

bind stepper_trapezoid_ramp_core stramp_checker u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_step_pulse    (o_step_pulse),
    .o_next_interval (o_next_interval),
    .o_is_running    (o_is_running),
    .o_move_done     (o_move_done)
);
`default_nettype wire

>>> tb/sv/tb_stepper_trapezoid_ramp_core.sv
`default_nettype none
module tb_stepper_trapezoid_ramp_core;
    import stramp_pkg::*;

    typedef struct packed {
        logic        step_pulse;
        logic        direction;
        logic [15:0] next_interval;
        logic [31:0] position_now;
        logic        is_running;
        logic        move_done;
    } ramp_out_t;

    // scoreboard: ramp predictor plus queue of expected outputs
    class ramp_scoreboard;
        logic [31:0] max_spd, acc_rate, min_spd, tclk;
        logic [31:0] pos, tgt, steps, decel_at, spd;
        logic [15:0] iv;
        logic [1:0]  ph;
        logic        run, dir;
        ramp_out_t   pending[$];
        int          errors;

        function void init();
            max_spd = RST_MAX_SPEED; acc_rate = RST_ACCEL_RATE;
            min_spd = RST_MIN_SPEED; tclk = RST_TIMER_CLOCK;
            pos = 0; tgt = 0; steps = 0; decel_at = 0; spd = 0;
            iv = IV_MAX; ph = PH_IDLE; run = 0; dir = 0; errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [26:0] v);
            case (idx)
                REG_MAX_SPEED:   max_spd = v[15:0];
                REG_ACCEL_RATE:  acc_rate = v[15:0];
                REG_MIN_SPEED:   min_spd = v[15:0];
                REG_TIMER_CLOCK: tclk = v;
                default: ;
            endcase
        endfunction

        function logic [31:0] nzw(logic [31:0] x);
            return (x == 0) ? 32'd1 : x;
        endfunction

        function logic [15:0] clip_iv(logic [63:0] v);
            if (v < 20) return 16'd20;
            if (v > 65535) return 16'd65535;
            return v[15:0];
        endfunction

        function logic [31:0] accel_dist(logic [31:0] s);
            logic [63:0] hi, lo;
            hi = s * s; hi = {32'd0, s} * {32'd0, s};
            lo = {32'd0, min_spd} * {32'd0, min_spd};
            if (hi <= lo) return 0;
            return 32'((hi - lo) / (64'd2 * nzw(acc_rate)));
        endfunction

        function logic [31:0] dist_left();
            longint d;
            d = longint'($signed(tgt)) - longint'($signed(pos));
            if (d < 0) d = -d;
            return 32'(d);
        endfunction

        function void begin_move(logic [31:0] t);
            longint d;
            logic [31:0] mag, a;
            d = longint'($signed(t)) - longint'($signed(pos));
            if (d == 0) return;
            if (d > 0) dir = 0;
            else begin
                dir = 1; d = -d;
            end
            mag = 32'(d);
            tgt = t;
            a = accel_dist(max_spd);
            if ({32'd0, mag} <= 64'd2 * a) decel_at = mag / 2;
            else decel_at = mag - a;
            ph = PH_ACCEL; run = 1; steps = 0; spd = min_spd;
            iv = clip_iv(tclk / nzw(min_spd));
        endfunction

        function logic take_step();
            logic [31:0] n, rem;
            logic [63:0] c, pd, q, nx;
            if (dir == 0) pos = pos + 1;
            else pos = pos - 1;
            steps = steps + 1;
            if (pos == tgt) begin
                ph = PH_IDLE; run = 0;
                return 1;
            end
            n = steps; c = iv; pd = c;
            case (ph)
                PH_ACCEL: begin
                    if (n > 0 && c > 10) begin
                        q = (64'd2 * c) / (64'd4 * n + 1);
                        if (q < c) pd = c - q;
                    end
                    spd = (pd != 0) ? 32'(tclk / pd) : 32'd0;
                    if (spd >= max_spd || n >= decel_at) begin
                        ph = PH_CONST;
                        pd = tclk / nzw(max_spd);
                        spd = max_spd;
                    end
                end
                PH_CONST: begin
                    pd = tclk / nzw(max_spd);
                    spd = max_spd;
                    rem = dist_left();
                    if ({32'd0, rem} <= {32'd0, accel_dist(spd)} + 1) ph = PH_DECEL;
                end
                PH_DECEL: begin
                    rem = dist_left();
                    if (rem <= 1) pd = tclk / nzw(min_spd);
                    else if (c < 65000) begin
                        nx = c + (64'd2 * c) / (64'd4 * rem + 1);
                        if (nx > 65535) nx = 65535;
                        pd = nx;
                    end
                    spd = (pd != 0) ? 32'(tclk / pd) : 32'd0;
                    if (spd < min_spd) begin
                        spd = min_spd;
                        pd = tclk / nzw(min_spd);
                    end
                end
                default: ;
            endcase
            iv = clip_iv(pd);
            return 0;
        endfunction

        // note an accepted request and queue its expected output
        function void note_request(logic [2:0] cmd, logic [31:0] val);
            ramp_out_t r;
            r = '0;
            case (cmd)
                CMD_ABS:  begin_move(val);
                CMD_REL:  begin_move(pos + val);
                CMD_STOP: begin
                    ph = PH_IDLE; run = 0;
                end
                CMD_SOFT: if (run) begin
                    ph = PH_DECEL; decel_at = 0;
                end
                CMD_TICK: if (run) begin
                    r.step_pulse = 1;
                    r.move_done = take_step();
                end
                CMD_HOME: begin
                    pos = 0; tgt = 0;
                end
                default: ;
            endcase
            r.direction = dir; r.next_interval = iv; r.position_now = pos;
            r.is_running = run;
            pending.push_back(r);
        endfunction

        function void check_result(ramp_out_t got);
            ramp_out_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.step_pulse !== e.step_pulse)
                $display("%0t: step_pulse exp %0d got %0d", $time, e.step_pulse, got.step_pulse);
            if (got.direction !== e.direction)
                $display("%0t: direction exp %0d got %0d", $time, e.direction, got.direction);
            if (got.next_interval !== e.next_interval)
                $display("%0t: next_interval exp %0d got %0d", $time,
                         e.next_interval, got.next_interval);
            if (got.position_now !== e.position_now)
                $display("%0t: position_now exp %0d got %0d", $time,
                         $signed(e.position_now), $signed(got.position_now));
            if (got.is_running !== e.is_running)
                $display("%0t: is_running exp %0d got %0d", $time, e.is_running, got.is_running);
            if (got.move_done !== e.move_done)
                $display("%0t: move_done exp %0d got %0d", $time, e.move_done, got.move_done);
            if (got !== e) errors++;
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_cfg_wr_en = 0;
    logic [1:0]         i_cfg_idx = '0;
    logic [26:0]        i_cfg_wdata = '0;
    logic               i_valid = 0;
    logic               o_ready;
    logic [2:0]         i_cmd = '0;
    logic signed [31:0] i_move_value = '0;
    logic               o_valid;
    logic               i_ready = 0;
    logic               o_step_pulse, o_direction, o_is_running, o_move_done;
    logic [15:0]        o_next_interval;
    logic signed [31:0] o_position_now;

    ramp_scoreboard sb;
    int  hold_off = 0;

    stepper_trapezoid_ramp_core dut (.*);

    always #4 i_clk = ~i_clk;

    // output side: check accepted results, stall on its own pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result({o_step_pulse, o_direction, o_next_interval,
                             o_position_now, o_is_running, o_move_done});
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 0;
        end else if (($time / 2000) % 5 == 0) i_ready <= 1;
        else i_ready <= ($urandom_range(0, 3) != 0);
    end

    // send one request and wait for its acceptance
    task automatic send_request(logic [2:0] cmd, logic [31:0] val);
        i_valid <= 1; i_cmd <= cmd; i_move_value <= val;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(cmd, val);
    endtask

    task automatic pause_sender(int n);
        i_valid <= 0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (130) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [26:0] v);
        i_cfg_wr_en <= 1; i_cfg_idx <= idx; i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        sb.write_reg(idx, v);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 8) - 4;
            default: return $urandom_range(0, 60) - 30;
        endcase
    endfunction

    // one move followed by a run of ticks, sometimes broken up
    task automatic move_sequence(int budget, output int used);
        int len;
        used = 0;
        send_request($urandom_range(0, 1) ? CMD_REL : CMD_ABS, pick_value()); used++;
        len = $urandom_range(5, 70);
        for (int k = 0; k < len && used < budget; k++) begin
            if ($urandom_range(0, 9) == 0) pause_sender($urandom_range(1, 12));
            case ($urandom_range(0, 40))
                0: send_request(CMD_STOP, $urandom);
                1: send_request(CMD_SOFT, $urandom);
                2: send_request(CMD_HOME, $urandom);
                3: send_request(3'($urandom_range(6, 7)), $urandom);
                4: send_request(CMD_REL, pick_value());
                default: send_request(CMD_TICK, $urandom);
            endcase
            used++;
        end
    endtask

    task automatic set_profile(int sel);
        case (sel)
            0: begin
                write_reg(REG_MAX_SPEED, 27'd65535); write_reg(REG_ACCEL_RATE, 27'd65535);
                write_reg(REG_MIN_SPEED, 27'd1); write_reg(REG_TIMER_CLOCK, 27'd72000000);
            end
            1: begin
                write_reg(REG_MAX_SPEED, 27'd1); write_reg(REG_ACCEL_RATE, 27'd1);
                write_reg(REG_MIN_SPEED, 27'd65535); write_reg(REG_TIMER_CLOCK, 27'd1);
            end
            2: begin
                write_reg(REG_MAX_SPEED, 27'd0); write_reg(REG_ACCEL_RATE, 27'd0);
                write_reg(REG_MIN_SPEED, 27'd0); write_reg(REG_TIMER_CLOCK, 27'd0);
            end
            3: begin
                write_reg(REG_MAX_SPEED, 27'($urandom_range(200, 5000)));
                write_reg(REG_ACCEL_RATE, 27'($urandom_range(500, 60000)));
                write_reg(REG_MIN_SPEED, 27'($urandom_range(10, 400)));
                write_reg(REG_TIMER_CLOCK, 27'($urandom_range(100000, 2000000)));
            end
            default: begin
                write_reg(REG_MAX_SPEED, 27'($urandom_range(1, 65535)));
                write_reg(REG_ACCEL_RATE, 27'($urandom_range(1, 65535)));
                write_reg(REG_MIN_SPEED, 27'($urandom_range(1, 65535)));
                write_reg(REG_TIMER_CLOCK, 27'($urandom & 27'h7ffffff));
            end
        endcase
    endtask

    initial begin
        int sent, used;
        sb = new();
        sb.init();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reset settings, every command and corner case
        send_request(CMD_TICK, 0);
        send_request(CMD_SOFT, 0);
        send_request(CMD_ABS, 0);
        send_request(CMD_ABS, 6);
        repeat (3) send_request(CMD_TICK, 0);
        send_request(CMD_ABS, 32'sh7fffffff);
        send_request(CMD_TICK, 0);
        send_request(CMD_ABS, 32'sh80000000);
        send_request(CMD_TICK, 0);
        send_request(CMD_SOFT, 0);
        send_request(CMD_TICK, 0);
        send_request(CMD_HOME, 0);
        send_request(CMD_TICK, 0);
        send_request(CMD_STOP, 0);
        send_request(3'd6, 32'hffffffff);
        send_request(3'd7, 0);
        send_request(CMD_REL, 32'hffffffff);
        send_request(CMD_REL, 2);
        send_request(CMD_TICK, 0);
        send_request(CMD_TICK, 0);
        drain();

        // random: settings changed between phases while idle
        sent = 25;
        for (int p = 0; sent < 1850; p++) begin
            set_profile(p % 6);
            for (int j = 0; j < 80; j += used) begin
                if (p == 2 && j == 0) hold_off = 400;
                move_sequence(80 - j, used);
                sent += used;
                if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 40));
            end
            drain();
        end
        if (sb.errors == 0) $display("stepper_trapezoid_ramp_core verification clean");
        else $display("stepper_trapezoid_ramp_core verification failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("stepper_trapezoid_ramp_core verification failed");
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
sv/stramp_pkg.sv
sv/stramp_div.sv
sv/stramp_dp.sv
sv/stramp_ctrl.sv
sv/stepper_trapezoid_ramp_core.sv
sv/stramp_checker.sv
tb/sv/tb_stepper_trapezoid_ramp_core.sv
